/* src/nggr_pkg.sv */
// Shared types, constants and helper functions for the GGA/RMC field extractor.
`timescale 1ns / 1ps
`default_nettype none
package nggr_pkg;

	// Fraction digits kept for the minutes of latitude and longitude (1..6)
	localparam int MINUTE_FRAC_DIGITS = 4;

	// Clamp for minutes, scaled by the fraction digits, and the factor to microunits
	localparam longint unsigned MINS_MAX    = 64'd12000 * (64'd10 ** MINUTE_FRAC_DIGITS);
	localparam longint unsigned ANGLE_MULT  = 64'd10 ** (6 - MINUTE_FRAC_DIGITS);

	// Command queue depth
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Characters of interest
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] CH_A     = 8'h41;

	typedef enum logic [3:0] {
		ROLE_NONE, ROLE_TIME, ROLE_LAT, ROLE_NS, ROLE_LON, ROLE_EW, ROLE_QUAL,
		ROLE_SATS, ROLE_ALT, ROLE_STATUS, ROLE_SPEED, ROLE_COURSE, ROLE_DATE
	} role_t;

	// One finished field (or end of sentence) handed from front to back
	typedef struct packed {
		role_t       role;
		logic        rmc;
		logic        comma;
		logic        last;
		logic [31:0] acc;
		logic [7:0]  deg;
		logic [3:0]  dcnt;
		logic [2:0]  frac;
		logic        minus;
		logic        seen;
		logic [7:0]  first;
	} cmd_t;

	function automatic role_t role_of(input logic rmc, input logic [3:0] idx);
		role_t r;
		r = ROLE_NONE;
		if (!rmc) begin
			case (idx)
				4'd1: r = ROLE_TIME;
				4'd2: r = ROLE_LAT;
				4'd3: r = ROLE_NS;
				4'd4: r = ROLE_LON;
				4'd5: r = ROLE_EW;
				4'd6: r = ROLE_QUAL;
				4'd7: r = ROLE_SATS;
				4'd9: r = ROLE_ALT;
				default: r = ROLE_NONE;
			endcase
		end else begin
			case (idx)
				4'd2: r = ROLE_STATUS;
				4'd7: r = ROLE_SPEED;
				4'd8: r = ROLE_COURSE;
				4'd9: r = ROLE_DATE;
				default: r = ROLE_NONE;
			endcase
		end
		return r;
	endfunction

	function automatic logic [2:0] frac_limit(input role_t r);
		logic [2:0] v;
		case (r)
			ROLE_LAT, ROLE_LON:     v = 3'(MINUTE_FRAC_DIGITS);
			ROLE_ALT:               v = 3'd1;
			ROLE_SPEED, ROLE_COURSE: v = 3'd2;
			default:                v = 3'd0;
		endcase
		return v;
	endfunction

	function automatic logic [1:0] degree_len(input role_t r);
		logic [1:0] v;
		case (r)
			ROLE_LAT: v = 2'd2;
			ROLE_LON: v = 2'd3;
			default:  v = 2'd0;
		endcase
		return v;
	endfunction

	function automatic logic [19:0] pw10(input logic [2:0] n);
		logic [19:0] v;
		case (n)
			3'd0: v = 20'd1;
			3'd1: v = 20'd10;
			3'd2: v = 20'd100;
			3'd3: v = 20'd1000;
			3'd4: v = 20'd10000;
			3'd5: v = 20'd100000;
			3'd6: v = 20'd1000000;
			default: v = 20'd1;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* src/nggr_front.sv */
// Front end: accepts characters, accumulates the current field, issues field commands.
`timescale 1ns / 1ps
`default_nettype none
module nggr_front
	import nggr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] char_in,
	input  wire logic       sentence_kind,
	input  wire logic       last_char,
	output logic            push,
	output cmd_t            push_data
);

	logic [3:0]  idx_q;
	logic [31:0] acc_q;
	logic [7:0]  deg_q;
	logic [3:0]  dcnt_q;
	logic [2:0]  frac_q;
	logic        point_q, minus_q, seen_q, stop_q;
	logic [7:0]  first_q;

	logic [31:0] acc_d;
	logic [7:0]  deg_d;
	logic [3:0]  dcnt_d;
	logic [2:0]  frac_d;
	logic        point_d, minus_d, seen_d, stop_d;
	logic [7:0]  first_d;

	role_t       role;
	logic [2:0]  lim;
	logic [1:0]  dlen;
	logic        is_digit, is_comma, done;
	logic [3:0]  dig;
	logic [35:0] acc_x10;
	logic [11:0] deg_x10;

	assign role     = role_of(sentence_kind, idx_q);
	assign lim      = frac_limit(role);
	assign dlen     = degree_len(role);
	assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign is_comma = (char_in == CH_COMMA);
	assign dig      = 4'(char_in - CH_ZERO);
	assign acc_x10  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + 36'(dig);
	assign deg_x10  = ({4'd0, deg_q} << 3) + ({4'd0, deg_q} << 1) + 12'(dig);

	// Advance the field accumulators by one character
	always_comb begin
		acc_d   = acc_q;
		deg_d   = deg_q;
		dcnt_d  = dcnt_q;
		frac_d  = frac_q;
		point_d = point_q;
		minus_d = minus_q;
		seen_d  = seen_q;
		stop_d  = stop_q;
		first_d = first_q;
		done    = 1'b0;
		if (!seen_q) begin
			seen_d  = 1'b1;
			first_d = char_in;
			if (dlen == 2'd0 && (char_in == CH_MINUS || char_in == CH_PLUS)) begin
				minus_d = (char_in == CH_MINUS);
				done    = 1'b1;
			end
		end
		if (!done && !stop_q) begin
			if ({2'd0, dlen} > dcnt_q) begin
				if (is_digit) begin
					deg_d  = (deg_x10 > 12'd255) ? 8'd255 : deg_x10[7:0];
					dcnt_d = (dcnt_q == 4'd15) ? dcnt_q : dcnt_q + 4'd1;
				end else begin
					stop_d = 1'b1;
				end
			end else if (is_digit) begin
				if (!(point_q && frac_q >= lim)) begin
					if (point_q) begin
						frac_d = frac_q + 3'd1;
					end
					acc_d  = (acc_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_x10[31:0];
					dcnt_d = (dcnt_q == 4'd15) ? dcnt_q : dcnt_q + 4'd1;
				end
			end else if (char_in == CH_DOT && lim != 3'd0 && !point_q) begin
				point_d = 1'b1;
			end else begin
				stop_d = 1'b1;
			end
		end
	end

	// Issue a command on a comma or on the last character
	always_comb begin
		push            = accept && (is_comma || last_char);
		push_data.role  = role;
		push_data.rmc   = sentence_kind;
		push_data.comma = is_comma;
		push_data.last  = last_char;
		push_data.acc   = acc_q;
		push_data.deg   = deg_q;
		push_data.dcnt  = dcnt_q;
		push_data.frac  = frac_q;
		push_data.minus = minus_q;
		push_data.seen  = seen_q;
		push_data.first = first_q;
	end

	// Update field state; clear it at a comma and at the end of a sentence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			acc_q   <= '0;
			deg_q   <= '0;
			dcnt_q  <= '0;
			frac_q  <= '0;
			point_q <= 1'b0;
			minus_q <= 1'b0;
			seen_q  <= 1'b0;
			stop_q  <= 1'b0;
			first_q <= '0;
		end else if (accept) begin
			if (is_comma || last_char) begin
				acc_q   <= '0;
				deg_q   <= '0;
				dcnt_q  <= '0;
				frac_q  <= '0;
				point_q <= 1'b0;
				minus_q <= 1'b0;
				seen_q  <= 1'b0;
				stop_q  <= 1'b0;
				first_q <= '0;
			end else begin
				acc_q   <= acc_d;
				deg_q   <= deg_d;
				dcnt_q  <= dcnt_d;
				frac_q  <= frac_d;
				point_q <= point_d;
				minus_q <= minus_d;
				seen_q  <= seen_d;
				stop_q  <= stop_d;
				first_q <= first_d;
			end
			if (last_char) begin
				idx_q <= '0;
			end else if (is_comma && idx_q != 4'd15) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/nggr_fifo.sv */
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module nggr_fifo
	import nggr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_data,
	input  wire logic pop,
	output cmd_t      pop_data,
	output logic      empty,
	output logic      full
);

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;

	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == (QAW+1)'(QDEPTH));
	assign pop_data = mem_q[rd_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/nggr_back.sv */
// Back end: scales finished fields, updates the record and emits it.
`timescale 1ns / 1ps
`default_nettype none
module nggr_back
	import nggr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_avail,
	input  cmd_t                    cmd,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [17:0]             time_hhmmss,
	output logic signed [27:0]      latitude_micro,
	output logic signed [28:0]      longitude_micro,
	output logic [3:0]              fix_quality,
	output logic [6:0]              satellites_used,
	output logic signed [20:0]      altitude_dm,
	output logic [19:0]             speed_centiknots,
	output logic [15:0]             course_centideg,
	output logic [18:0]             date_ddmmyy
);

	logic advance;

	cmd_t        cmd_s1, cmd_s2, cmd_s3;
	logic        vld_s1, vld_s2, vld_s3;
	logic [51:0] prod_s1;
	logic        aok_s1, aok_s2, aok_s3;
	logic signed [20:0] plain_s2, plain_s3;
	logic [31:0] x_s2;
	logic [27:0] degmic_s2, degmic_s3;
	logic [27:0] q_s3;

	logic               out_valid_q;
	logic               inactive_q;
	logic [17:0]        time_q;
	logic signed [27:0] lat_q;
	logic signed [28:0] lon_q;
	logic [3:0]         qual_q;
	logic [6:0]         sats_q;
	logic signed [20:0] alt_q;
	logic [19:0]        speed_q;
	logic [15:0]        course_q;
	logic [18:0]        date_q;

	assign advance = !out_valid_q || !out_stall;
	assign pop     = advance && cmd_avail;

	// Stage 1: scale the accumulated digits to the field's fixed point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= cmd_avail;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1  <= cmd;
			prod_s1 <= 52'(cmd.acc) * 52'(pw10(frac_limit(cmd.role) - cmd.frac));
			aok_s1  <= cmd.dcnt > {2'd0, degree_len(cmd.role)};
		end
	end

	// Stage 2: sign and clamp plain values; prepare minutes for the divide by 60
	logic signed [52:0] sval;
	logic signed [52:0] lo_v, hi_v;
	logic [33:0]        mins;
	logic [63:0]        mval;

	always_comb begin
		sval = $signed({1'b0, prod_s1});
		if (cmd_s1.minus) begin
			sval = -sval;
		end
		case (cmd_s1.role)
			ROLE_TIME:   begin lo_v = 53'sd0;       hi_v = 53'sd235959;  end
			ROLE_QUAL:   begin lo_v = 53'sd0;       hi_v = 53'sd9;       end
			ROLE_SATS:   begin lo_v = 53'sd0;       hi_v = 53'sd99;      end
			ROLE_ALT:    begin lo_v = -53'sd100000; hi_v = 53'sd1000000; end
			ROLE_SPEED:  begin lo_v = 53'sd0;       hi_v = 53'sd999999;  end
			ROLE_COURSE: begin lo_v = 53'sd0;       hi_v = 53'sd36000;   end
			ROLE_DATE:   begin lo_v = 53'sd0;       hi_v = 53'sd311299;  end
			default:     begin lo_v = 53'sd0;       hi_v = 53'sd0;       end
		endcase
		mins = (64'(prod_s1) > MINS_MAX) ? 34'(MINS_MAX) : prod_s1[33:0];
		mval = 64'(mins) * ANGLE_MULT + 64'd30;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s2    <= cmd_s1;
			aok_s2    <= aok_s1;
			plain_s2  <= (sval < lo_v) ? 21'(lo_v) : ((sval > hi_v) ? 21'(hi_v) : 21'(sval));
			x_s2      <= mval[33:2];
			degmic_s2 <= 28'(32'(cmd_s1.deg) * 32'd1000000);
		end
	end

	// Stage 3: divide by 15 through a reciprocal multiply (finishes the divide by 60)
	logic [63:0] recip;
	assign recip = 64'(x_s2) * 64'h0000_0000_8888_8889;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (advance) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s3    <= cmd_s2;
			aok_s3    <= aok_s2;
			plain_s3  <= plain_s2;
			degmic_s3 <= degmic_s2;
			q_s3      <= recip[62:35];
		end
	end

	// Commit: form the angle and update the record
	logic [28:0]  micro;
	logic [28:0]  angle;
	logic [28:0]  alim;
	logic         commit;
	logic         blocked;

	always_comb begin
		micro   = 29'(degmic_s3) + 29'(q_s3);
		alim    = (cmd_s3.role == ROLE_LAT) ? 29'd90000000 : 29'd180000000;
		angle   = !aok_s3 ? 29'd0 : ((micro > alim) ? alim : micro);
		commit  = advance && vld_s3;
		blocked = cmd_s3.rmc && inactive_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			inactive_q  <= 1'b0;
			time_q      <= '0;
			lat_q       <= '0;
			lon_q       <= '0;
			qual_q      <= '0;
			sats_q      <= '0;
			alt_q       <= '0;
			speed_q     <= '0;
			course_q    <= '0;
			date_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= commit && cmd_s3.last;
			end
			if (commit) begin
				if (cmd_s3.comma && !blocked) begin
					case (cmd_s3.role)
						ROLE_TIME:   time_q   <= plain_s3[17:0];
						ROLE_LAT:    lat_q    <= $signed(angle[27:0]);
						ROLE_NS:     if (cmd_s3.seen && cmd_s3.first == CH_S) begin
							lat_q <= -lat_q;
						end
						ROLE_LON:    lon_q    <= $signed(angle);
						ROLE_EW:     if (cmd_s3.seen && cmd_s3.first == CH_W) begin
							lon_q <= -lon_q;
						end
						ROLE_QUAL:   qual_q   <= plain_s3[3:0];
						ROLE_SATS:   sats_q   <= plain_s3[6:0];
						ROLE_ALT:    alt_q    <= plain_s3;
						ROLE_STATUS: if (!cmd_s3.seen || cmd_s3.first != CH_A) begin
							inactive_q <= 1'b1;
						end
						ROLE_SPEED:  speed_q  <= plain_s3[19:0];
						ROLE_COURSE: course_q <= plain_s3[15:0];
						ROLE_DATE:   date_q   <= plain_s3[18:0];
						default: ;
					endcase
				end
				if (cmd_s3.last) begin
					inactive_q <= 1'b0;
				end
			end
		end
	end

	// The record holds while an emitted item waits, so it drives the outputs directly
	assign out_valid        = out_valid_q;
	assign time_hhmmss      = time_q;
	assign latitude_micro   = lat_q;
	assign longitude_micro  = lon_q;
	assign fix_quality      = qual_q;
	assign satellites_used  = sats_q;
	assign altitude_dm      = alt_q;
	assign speed_centiknots = speed_q;
	assign course_centideg  = course_q;
	assign date_ddmmyy      = date_q;

endmodule
`default_nettype wire

/* src/nmea_gga_rmc_field_extractor.sv */
// A record item follows the last character via the queue and stages 1 to 3.
// Throughput: one character per cycle; the front stalls only when the 4-entry
// command queue is full, which happens when the output is held by out_stall.
// The back pipeline (scale, clamp, divide-by-60 multiply, commit) moves as one.
// Reset: arst_n clears the record to zero, the field state and the queue.
// Top level: GGA/RMC character-stream field extractor.
`timescale 1ns / 1ps
`default_nettype none
module nmea_gga_rmc_field_extractor
	import nggr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         char_in,
	input  wire logic               sentence_kind,
	input  wire logic               last_char,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [17:0]             time_hhmmss,
	output logic signed [27:0]      latitude_micro,
	output logic signed [28:0]      longitude_micro,
	output logic [3:0]              fix_quality,
	output logic [6:0]              satellites_used,
	output logic signed [20:0]      altitude_dm,
	output logic [19:0]             speed_centiknots,
	output logic [15:0]             course_centideg,
	output logic [18:0]             date_ddmmyy
);

	logic accept, push, pop, q_empty, q_full;
	cmd_t push_data, pop_data;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	nggr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.char_in       (char_in),
		.sentence_kind (sentence_kind),
		.last_char     (last_char),
		.push          (push),
		.push_data     (push_data)
	);

	nggr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty),
		.full      (q_full)
	);

	nggr_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_avail        (!q_empty),
		.cmd              (pop_data),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.time_hhmmss      (time_hhmmss),
		.latitude_micro   (latitude_micro),
		.longitude_micro  (longitude_micro),
		.fix_quality      (fix_quality),
		.satellites_used  (satellites_used),
		.altitude_dm      (altitude_dm),
		.speed_centiknots (speed_centiknots),
		.course_centideg  (course_centideg),
		.date_ddmmyy      (date_ddmmyy)
	);

	// Never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full)) else $error("command pushed into full queue");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty) else $error("command popped from empty queue");

	// A held result keeps the back end frozen, so the queue cannot drain
	a_hold_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !pop) else $error("pop while output held");

endmodule
`default_nettype wire
